@@ design/dsc_pkg.sv @@
// Package for the source-chain DMA channel: bus function codes, register
// selects, request kinds, tag fields and masks.
// No dependencies; used by dma_source_chain_channel_top.
package dsc_pkg;

    // Function of an input item
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_TAG   = 2'd3;

    // Register selects
    localparam logic [2:0] SEL_CTRL  = 3'd0;
    localparam logic [2:0] SEL_MADR  = 3'd1;
    localparam logic [2:0] SEL_QWC   = 3'd2;
    localparam logic [2:0] SEL_TADR  = 3'd3;
    localparam logic [2:0] SEL_SAVE0 = 3'd4;
    localparam logic [2:0] SEL_SAVE1 = 3'd5;
    localparam logic [2:0] SEL_SADR  = 3'd6;
    localparam logic [2:0] SEL_STAT  = 3'd7;

    // Request kinds
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_DATA = 3'd1;
    localparam logic [2:0] KIND_TAG  = 3'd2;
    localparam logic [2:0] KIND_DONE = 3'd3;
    localparam logic [2:0] KIND_BAD  = 3'd4;

    // Tag ids
    localparam logic [2:0] TAG_REFE = 3'd0;
    localparam logic [2:0] TAG_CNT  = 3'd1;
    localparam logic [2:0] TAG_NEXT = 3'd2;
    localparam logic [2:0] TAG_REF  = 3'd3;
    localparam logic [2:0] TAG_REFS = 3'd4;
    localparam logic [2:0] TAG_END  = 3'd7;
    // ids with no meaning in a source chain
    localparam logic [2:0] TAG_BAD_A = 3'd5;
    localparam logic [2:0] TAG_BAD_B = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_DMAC_ENABLE = 2'd0;
    localparam logic [1:0] CFG_PRIO_ENABLES = 2'd1;

    localparam int unsigned NUM_CHANNELS = 10;
    localparam int unsigned DEF_CHANNEL_INDEX = 6;
    localparam int unsigned START_BIT = 8;
    localparam int unsigned TIE_BIT = 7;

    localparam logic [31:0] MADR_MASK = 32'h01ff_fff0;
    localparam logic [31:0] QW_BYTES  = 32'd16;

    typedef logic [NUM_CHANNELS-1:0] t_chan_vec;

endpackage

@@ design/dma_source_chain_channel_top.sv @@
// Top level of the source-chain DMA channel with the shared status register.
// Depends on dsc_pkg.
//
// One DMA channel walking a source chain of tags. Each item is a bus register
// write, a bus register read, an advance tick or a delivered tag word, and
// every item gives exactly one result: read data, a request (data quadword
// read, tag fetch, transfer done or bad tag error) with its address, and the
// interrupt line and condition flag as they stand after the item. An item is
// registered on entry, its whole effect on the channel registers is worked
// out combinationally, and the result is held in an output register, so one
// item is taken every cycle while the result side does not stall; a stall
// there backs up through the two registers only. The controller enable and the
// channel enable mask must be written through the configuration port while
// the channel is idle; the block itself does not enforce it.
module dma_source_chain_channel_top #(
    parameter int unsigned CHANNEL_INDEX = dsc_pkg::DEF_CHANNEL_INDEX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_reg_select,
    input  logic [31:0] i_write_data,
    input  logic [63:0] i_tag_word,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_request_kind,
    output logic [31:0] o_request_address,
    output logic        o_irq_line,
    output logic        o_cond_flag,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // status bit set by this channel at the end of a transfer
    localparam logic [31:0] ChanBit = 32'd1 << CHANNEL_INDEX;

    // configuration
    logic              r_dmac_en;
    dsc_pkg::t_chan_vec r_prio_en;

    // input register
    logic        r_in_vld;
    logic [1:0]  r_func;
    logic [2:0]  r_sel;
    logic [31:0] r_wdata;
    logic [63:0] r_tag;

    // channel state
    logic [31:0] r_ctrl, n_ctrl;
    logic [31:0] r_madr, n_madr;
    logic [15:0] r_qwc,  n_qwc;
    logic [31:0] r_tadr, n_tadr;
    logic [31:0] r_save0, n_save0;
    logic [31:0] r_save1, n_save1;
    logic [31:0] r_sadr, n_sadr;
    logic [31:0] r_stat, n_stat;
    logic        r_run,  n_run;
    logic        r_endp, n_endp;

    // result
    logic        r_out_vld;
    logic [31:0] r_rdata, n_rdata;
    logic [2:0]  r_kind,  n_kind;
    logic [31:0] r_raddr, n_raddr;
    logic        r_irq,   n_irq;
    logic        r_cond,  n_cond;

    logic        adv;

    // tag fields
    logic [2:0]  tag_id;
    logic [31:0] tag_addr;
    logic        tag_irq;
    logic [15:0] tag_cnt;

    // Move the held item into the result register when that is free or being taken.
    assign adv         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !adv;
    assign o_cfg_ready = 1'b1;

    assign tag_id   = r_tag[30:28];
    assign tag_addr = {1'b0, r_tag[62:32]};
    assign tag_irq  = r_tag[31];
    assign tag_cnt  = r_tag[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmac_en <= 1'b0;
            r_prio_en <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dsc_pkg::CFG_DMAC_ENABLE:  r_dmac_en <= i_cfg_data[0];
                dsc_pkg::CFG_PRIO_ENABLES: r_prio_en <= i_cfg_data[dsc_pkg::NUM_CHANNELS-1:0];
                default: ;
            endcase
        end
    end

    // Input register: load on acceptance, drop once passed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_func  <= i_func;
            r_sel   <= i_reg_select;
            r_wdata <= i_write_data;
            r_tag   <= i_tag_word;
        end
    end

    // Work out the effect of the held item on the channel.
    always_comb begin
        n_ctrl  = r_ctrl;
        n_madr  = r_madr;
        n_qwc   = r_qwc;
        n_tadr  = r_tadr;
        n_save0 = r_save0;
        n_save1 = r_save1;
        n_sadr  = r_sadr;
        n_stat  = r_stat;
        n_run   = r_run;
        n_endp  = r_endp;
        n_rdata = '0;
        n_kind  = dsc_pkg::KIND_NONE;
        n_raddr = '0;

        case (r_func)
            dsc_pkg::FUNC_WRITE: begin
                case (r_sel)
                    dsc_pkg::SEL_CTRL: begin
                        n_ctrl = r_wdata;
                        if (r_wdata[dsc_pkg::START_BIT] && r_dmac_en) begin
                            n_run  = 1'b1;
                            n_endp = 1'b0;
                        end else begin
                            n_run = 1'b0;
                        end
                    end
                    dsc_pkg::SEL_MADR:  n_madr  = r_wdata & dsc_pkg::MADR_MASK;
                    dsc_pkg::SEL_QWC:   n_qwc   = r_wdata[15:0];
                    dsc_pkg::SEL_TADR:  n_tadr  = r_wdata;
                    dsc_pkg::SEL_SAVE0: n_save0 = r_wdata;
                    dsc_pkg::SEL_SAVE1: n_save1 = r_wdata;
                    dsc_pkg::SEL_SADR:  n_sadr  = r_wdata;
                    default: begin
                        // clear low half where written 1, toggle high half
                        n_stat = (r_stat & ~{16'h0000, r_wdata[15:0]})
                                 ^ {r_wdata[31:16], 16'h0000};
                    end
                endcase
            end
            dsc_pkg::FUNC_READ: begin
                case (r_sel)
                    dsc_pkg::SEL_CTRL:  n_rdata = r_ctrl;
                    dsc_pkg::SEL_MADR:  n_rdata = r_madr;
                    dsc_pkg::SEL_QWC:   n_rdata = {16'h0000, r_qwc};
                    dsc_pkg::SEL_TADR:  n_rdata = r_tadr;
                    dsc_pkg::SEL_SAVE0: n_rdata = r_save0;
                    dsc_pkg::SEL_SAVE1: n_rdata = r_save1;
                    dsc_pkg::SEL_SADR:  n_rdata = r_sadr;
                    default:            n_rdata = r_stat;
                endcase
            end
            dsc_pkg::FUNC_TICK: begin
                if (r_run) begin
                    if (r_qwc != 16'h0000) begin
                        n_kind  = dsc_pkg::KIND_DATA;
                        n_raddr = r_madr;
                        n_madr  = r_madr + dsc_pkg::QW_BYTES;
                        n_qwc   = r_qwc - 16'd1;
                    end else if (r_endp) begin
                        // finish: flag this channel, stop the walk
                        n_kind = dsc_pkg::KIND_DONE;
                        n_stat = r_stat | ChanBit;
                        n_ctrl[dsc_pkg::START_BIT] = 1'b0;
                        n_run  = 1'b0;
                        n_endp = 1'b0;
                    end else begin
                        n_kind  = dsc_pkg::KIND_TAG;
                        n_raddr = r_tadr;
                    end
                end
            end
            default: begin
                // tag word; ignore it unless one is awaited
                if (r_run && (r_qwc == 16'h0000) && !r_endp) begin
                    if (tag_id == dsc_pkg::TAG_BAD_A || tag_id == dsc_pkg::TAG_BAD_B) begin
                        n_kind  = dsc_pkg::KIND_BAD;
                        n_raddr = r_tadr;
                        n_ctrl[dsc_pkg::START_BIT] = 1'b0;
                        n_run  = 1'b0;
                        n_endp = 1'b0;
                    end else begin
                        n_qwc  = tag_cnt;
                        n_ctrl = {r_tag[31:16], r_ctrl[15:0]};
                        case (tag_id)
                            dsc_pkg::TAG_REFE: begin
                                n_madr = tag_addr;
                                n_tadr = r_tadr + dsc_pkg::QW_BYTES;
                                n_endp = 1'b1;
                            end
                            dsc_pkg::TAG_CNT: begin
                                n_madr = r_tadr + dsc_pkg::QW_BYTES;
                                n_tadr = r_tadr + dsc_pkg::QW_BYTES
                                         + {12'h000, tag_cnt, 4'h0};
                            end
                            dsc_pkg::TAG_NEXT: begin
                                n_madr = r_tadr + dsc_pkg::QW_BYTES;
                                n_tadr = tag_addr;
                            end
                            dsc_pkg::TAG_REF, dsc_pkg::TAG_REFS: begin
                                n_madr = tag_addr;
                                n_tadr = r_tadr + dsc_pkg::QW_BYTES;
                            end
                            default: begin
                                n_madr = r_tadr + dsc_pkg::QW_BYTES;
                                n_endp = 1'b1;
                            end
                        endcase
                        // irq with tie ends the chain after this tag
                        if (r_ctrl[dsc_pkg::TIE_BIT] && tag_irq) begin
                            n_endp = 1'b1;
                        end
                    end
                end
            end
        endcase

        n_irq  = |(n_stat[dsc_pkg::NUM_CHANNELS-1:0] & n_stat[16 +: dsc_pkg::NUM_CHANNELS]);
        n_cond = &(~r_prio_en | n_stat[dsc_pkg::NUM_CHANNELS-1:0]);
    end

    // Channel state: advance only as an item passes into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= '0;
            r_madr  <= '0;
            r_qwc   <= '0;
            r_tadr  <= '0;
            r_save0 <= '0;
            r_save1 <= '0;
            r_sadr  <= '0;
            r_stat  <= '0;
            r_run   <= 1'b0;
            r_endp  <= 1'b0;
        end else if (adv) begin
            r_ctrl  <= n_ctrl;
            r_madr  <= n_madr;
            r_qwc   <= n_qwc;
            r_tadr  <= n_tadr;
            r_save0 <= n_save0;
            r_save1 <= n_save1;
            r_sadr  <= n_sadr;
            r_stat  <= n_stat;
            r_run   <= n_run;
            r_endp  <= n_endp;
        end
    end

    // Result register: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rdata <= n_rdata;
            r_kind  <= n_kind;
            r_raddr <= n_raddr;
            r_irq   <= n_irq;
            r_cond  <= n_cond;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_read_data       = r_rdata;
    assign o_request_kind    = r_kind;
    assign o_request_address = r_raddr;
    assign o_irq_line        = r_irq;
    assign o_cond_flag       = r_cond;

    // A running channel always has its start bit set.
    a_run_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_ctrl[dsc_pkg::START_BIT])
        else $error("channel running with start bit clear");

    // A stopped channel issues no request.
    a_idle_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_run |-> n_kind == dsc_pkg::KIND_NONE)
        else $error("request from a stopped channel");

    // Done leaves the channel stopped with its status bit set.
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_kind == dsc_pkg::KIND_DONE |=> !r_run && r_stat[CHANNEL_INDEX])
        else $error("transfer done without stop and status");

    // A data read advances the address by one quadword and counts down.
    a_data_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_kind == dsc_pkg::KIND_DATA |=>
            r_madr == $past(r_madr) + dsc_pkg::QW_BYTES && r_qwc == $past(r_qwc) - 16'd1)
        else $error("data read did not step address and count");

endmodule
